// File: rtl/ibc_pkg.sv
// shared constants and types for the imu bias calibrator
`timescale 1ns / 1ps
package ibc_pkg;

  localparam int unsigned AXES   = 3;
  localparam int unsigned LANES  = 6;
  localparam int unsigned RAW_W  = 16;
  localparam int unsigned CORR_W = 17;
  localparam int unsigned IN_W   = LANES * RAW_W;
  localparam int unsigned BIAS_LO = AXES * CORR_W;
  localparam int unsigned BIAS_HI = BIAS_LO + LANES * RAW_W - 1;
  localparam int unsigned OUT_W  = 152;
  localparam int unsigned PAD_W  = OUT_W - BIAS_HI - 1;

  typedef logic signed [RAW_W-1:0]  raw_t;
  typedef logic signed [CORR_W-1:0] corr_t;

  typedef struct packed {
    logic acc;
    logic ld1;
    logic ld2;
    logic ld3;
    logic bias_we;
  } lane_ctrl_t;

endpackage

// File: rtl/ibc_lane.sv
// one axis lane: running sum, constant divide pipeline and bias register
`timescale 1ns / 1ps
module ibc_lane #(
  parameter int unsigned CAL_SAMPLES = 200
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ibc_pkg::lane_ctrl_t ctrl_i,
  input  ibc_pkg::raw_t       sample_i,
  output ibc_pkg::raw_t       bias_o
);

  localparam int unsigned SW = ibc_pkg::RAW_W + $clog2(CAL_SAMPLES);
  localparam int unsigned K  = SW;
  localparam int unsigned MW = K + 1;
  localparam int unsigned PW = SW + MW;
  localparam logic [MW-1:0] Recip = MW'((65'd1 << K) / CAL_SAMPLES);
  localparam logic [SW-1:0] Div   = SW'(CAL_SAMPLES);

  logic signed [SW-1:0] sum_q, sum_d, s1_sum_q;
  logic [SW-1:0]        abs1;
  logic [PW-1:0]        s2_prod_q;
  logic [SW-1:0]        s2_abs_q, s3_abs_q, s3_qn_q, rem3;
  logic                 s2_neg_q, s3_neg_q;
  logic [15:0]          q2, s3_q_q;
  logic [16:0]          qc3;
  ibc_pkg::raw_t        bias_new, bias_q;

  assign sum_d = sum_q + SW'(sample_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      bias_q <= '0;
    end else begin
      if (ctrl_i.acc) begin
        sum_q <= sum_d;
      end
      if (ctrl_i.bias_we) begin
        bias_q <= bias_new;
      end
    end
  end

  // magnitude times reciprocal, then one correction step
  assign abs1 = s1_sum_q[SW-1] ? SW'(-s1_sum_q) : SW'(s1_sum_q);
  assign q2   = 16'(s2_prod_q >> K);
  assign rem3 = s3_abs_q - s3_qn_q;
  assign qc3  = 17'(s3_q_q) + 17'(rem3 >= Div);
  assign bias_new = s3_neg_q ? 16'(-qc3) : 16'(qc3);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld1) begin
      s1_sum_q <= sum_d;
    end
    if (ctrl_i.ld2) begin
      s2_prod_q <= PW'(abs1) * PW'(Recip);
      s2_abs_q  <= abs1;
      s2_neg_q  <= s1_sum_q[SW-1];
    end
    if (ctrl_i.ld3) begin
      s3_q_q   <= q2;
      s3_qn_q  <= SW'(SW'(q2) * Div);
      s3_abs_q <= s2_abs_q;
      s3_neg_q <= s2_neg_q;
    end
  end

  assign bias_o = ctrl_i.bias_we ? bias_new : bias_q;

endmodule

// File: rtl/imu_bias_calibrator_top.sv
// imu bias calibrator top level: control pipeline, six lanes and output merge
// an input transaction passes each pipeline stage register and the output register
// throughput: one sample per cycle, every stage advances each cycle unless the output stalls
// a stalled output keeps its transaction while earlier stages keep filling
// reset clears valid bits, sums, sample count, calibrated flag and biases
`timescale 1ns / 1ps
module imu_bias_calibrator_top #(
  parameter int unsigned CAL_SAMPLES = 200
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z
  input  logic [ibc_pkg::IN_W-1:0]   s_axis_tdata_i,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // gyro_corr_x/y/z, gyro_bias_x/y/z, accel_bias_x/y/z, zero pad
  output logic [ibc_pkg::OUT_W-1:0]  m_axis_tdata_o,
  // calibrated
  output logic                       m_axis_tuser_o
);

  localparam int unsigned CW = $clog2(CAL_SAMPLES + 1);
  localparam logic [CW-1:0] LastCount = CW'(CAL_SAMPLES);

  logic [CW-1:0] count_q, count_inc;
  logic          done_q, accept, complete;
  logic          v1_q, v2_q, v3_q, vo_q;
  logic          dn1_q, dn2_q, dn3_q, cp1_q, cp2_q, cp3_q;
  logic          out_ld, r1, r2, r3;
  ibc_pkg::raw_t g1_q [ibc_pkg::AXES];
  ibc_pkg::raw_t g2_q [ibc_pkg::AXES];
  ibc_pkg::raw_t g3_q [ibc_pkg::AXES];
  ibc_pkg::raw_t bias [ibc_pkg::LANES];
  ibc_pkg::raw_t ob_q [ibc_pkg::LANES];
  ibc_pkg::corr_t oc_q [ibc_pkg::AXES];
  logic          ocal_q;
  ibc_pkg::lane_ctrl_t lane_ctrl;

  assign out_ld = !vo_q || m_axis_tready_i;
  assign r3     = !v3_q || out_ld;
  assign r2     = !v2_q || r3;
  assign r1     = !v1_q || r2;
  assign s_axis_tready_o = r1;

  assign accept    = s_axis_tvalid_i && r1;
  assign count_inc = count_q + CW'(1);
  assign complete  = !done_q && (count_inc == LastCount);

  assign lane_ctrl.acc     = accept && !done_q;
  assign lane_ctrl.ld1     = r1;
  assign lane_ctrl.ld2     = r2;
  assign lane_ctrl.ld3     = r3;
  assign lane_ctrl.bias_we = out_ld && v3_q && cp3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      vo_q    <= 1'b0;
    end else begin
      if (accept && !done_q) begin
        count_q <= count_inc;
        done_q  <= complete;
      end
      if (r1) v1_q <= s_axis_tvalid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (out_ld) vo_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1) begin
      dn1_q <= done_q || complete;
      cp1_q <= complete;
      for (int i = 0; i < ibc_pkg::AXES; i++) begin
        g1_q[i] <= s_axis_tdata_i[ibc_pkg::RAW_W*i +: ibc_pkg::RAW_W];
      end
    end
    if (r2) begin
      dn2_q <= dn1_q;
      cp2_q <= cp1_q;
      g2_q  <= g1_q;
    end
    if (r3) begin
      dn3_q <= dn2_q;
      cp3_q <= cp2_q;
      g3_q  <= g2_q;
    end
    if (out_ld) begin
      ocal_q <= dn3_q;
      ob_q   <= bias;
      for (int i = 0; i < ibc_pkg::AXES; i++) begin
        oc_q[i] <= dn3_q ? (17'(g3_q[i]) - 17'(bias[i])) : 17'(g3_q[i]);
      end
    end
  end

  for (genvar j = 0; j < ibc_pkg::LANES; j++) begin : g_lane
    ibc_lane #(
      .CAL_SAMPLES(CAL_SAMPLES)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (lane_ctrl),
      .sample_i(s_axis_tdata_i[ibc_pkg::RAW_W*j +: ibc_pkg::RAW_W]),
      .bias_o  (bias[j])
    );
  end

  assign m_axis_tvalid_o = vo_q;
  assign m_axis_tuser_o  = ocal_q;
  assign m_axis_tdata_o  = {{ibc_pkg::PAD_W{1'b0}},
                            ob_q[5], ob_q[4], ob_q[3], ob_q[2], ob_q[1], ob_q[0],
                            oc_q[2], oc_q[1], oc_q[0]};

endmodule

// File: rtl/ibc_checker.sv
// port-level checker for the imu bias calibrator and its bind
`timescale 1ns / 1ps
module ibc_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      m_axis_tvalid_o,
  input logic                      m_axis_tready_i,
  input logic [ibc_pkg::OUT_W-1:0] m_axis_tdata_o,
  input logic                      m_axis_tuser_o
);

  logic        seen_q;
  logic [95:0] bias_ref_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= 1'b0;
      bias_ref_q <= '0;
    end else if (m_axis_tvalid_o && m_axis_tready_i && m_axis_tuser_o && !seen_q) begin
      seen_q     <= 1'b1;
      bias_ref_q <= m_axis_tdata_o[ibc_pkg::BIAS_HI:ibc_pkg::BIAS_LO];
    end
  end

  // stalled output transaction holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("output changed while stalled");

  // once calibrated, the flag stays and biases freeze
  a_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && seen_q |->
      m_axis_tuser_o && (m_axis_tdata_o[ibc_pkg::BIAS_HI:ibc_pkg::BIAS_LO] == bias_ref_q))
    else $error("calibration state changed after completion");

  // biases read zero before calibration
  a_zero_bias: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |->
      m_axis_tdata_o[ibc_pkg::BIAS_HI:ibc_pkg::BIAS_LO] == '0)
    else $error("nonzero bias before calibration");

  // raw pass-through is a sign-extended 16-bit value
  a_raw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |->
      (m_axis_tdata_o[16] == m_axis_tdata_o[15]) &&
      (m_axis_tdata_o[33] == m_axis_tdata_o[32]) &&
      (m_axis_tdata_o[50] == m_axis_tdata_o[49]))
    else $error("uncalibrated gyro value out of raw range");

endmodule

bind imu_bias_calibrator_top ibc_checker u_ibc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tuser_o (m_axis_tuser_o)
);
